@@ rtl/nps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Types, step codes and the control store of the priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int unsigned TIME_OUT_W = 21;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arr;
    logic [15:0] run;
    logic [7:0]  prio;
  } job_t;

  typedef enum logic [3:0] {
    STEP_IDLE        = 4'd0,
    STEP_INIT        = 4'd1,
    STEP_SCAN_START  = 4'd2,
    STEP_SCAN        = 4'd3,
    STEP_CHECK_FOUND = 4'd4,
    STEP_CHECK_PEND  = 4'd5,
    STEP_ADVANCE     = 4'd6,
    STEP_PICK_START  = 4'd7,
    STEP_PICK_END    = 4'd8,
    STEP_EMIT        = 4'd9,
    STEP_BRANCH      = 4'd10,
    STEP_FINISH      = 4'd11
  } step_e;

  typedef enum logic [2:0] {
    COND_NEVER        = 3'd0,
    COND_ALWAYS       = 3'd1,
    COND_ACC_LAST     = 3'd2,
    COND_MORE_ENTRIES = 3'd3,
    COND_FOUND        = 3'd4,
    COND_NO_PEND      = 3'd5,
    COND_OUT_FREE     = 3'd6,
    COND_MORE_JOBS    = 3'd7
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    logic  load;
    logic  init;
    logic  scan_clr;
    logic  scan;
    logic  set_time;
    logic  pick_start;
    logic  pick_end;
    logic  emit;
    logic  finish;
    cond_e cond;
    step_e target;
    logic  stay;
  } ctrl_t;

  // Datapath flags tested by conditional jumps.
  typedef struct packed {
    logic acc_last;
    logic more_entries;
    logic found;
    logic no_pend;
    logic out_free;
    logic more_jobs;
  } status_t;

  function automatic ctrl_t ucode(input step_e step);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        w.load   = 1'b1;
        w.cond   = COND_ACC_LAST;
        w.target = STEP_INIT;
        w.stay   = 1'b1;
      end
      STEP_INIT:       w.init = 1'b1;
      STEP_SCAN_START: w.scan_clr = 1'b1;
      STEP_SCAN: begin
        w.scan   = 1'b1;
        w.cond   = COND_MORE_ENTRIES;
        w.target = STEP_SCAN;
      end
      STEP_CHECK_FOUND: begin
        w.cond   = COND_FOUND;
        w.target = STEP_PICK_START;
      end
      STEP_CHECK_PEND: begin
        w.cond   = COND_NO_PEND;
        w.target = STEP_FINISH;
      end
      STEP_ADVANCE: begin
        w.set_time = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_SCAN_START;
      end
      STEP_PICK_START: w.pick_start = 1'b1;
      STEP_PICK_END:   w.pick_end = 1'b1;
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.target = STEP_BRANCH;
        w.stay   = 1'b1;
      end
      STEP_BRANCH: begin
        w.cond   = COND_MORE_JOBS;
        w.target = STEP_SCAN_START;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/nps_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module nps_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nps_pkg::status_t status_i,
  output nps_pkg::ctrl_t   ctrl_o
);

  nps_pkg::step_e pc_q, pc_d;
  nps_pkg::ctrl_t word;
  logic           take;

  assign word = nps_pkg::ucode(pc_q);

  // Next step
  always_comb begin
    case (word.cond)
      nps_pkg::COND_NEVER:        take = 1'b0;
      nps_pkg::COND_ALWAYS:       take = 1'b1;
      nps_pkg::COND_ACC_LAST:     take = status_i.acc_last;
      nps_pkg::COND_MORE_ENTRIES: take = status_i.more_entries;
      nps_pkg::COND_FOUND:        take = status_i.found;
      nps_pkg::COND_NO_PEND:      take = status_i.no_pend;
      nps_pkg::COND_OUT_FREE:     take = status_i.out_free;
      nps_pkg::COND_MORE_JOBS:    take = status_i.more_jobs;
      default:                    take = 1'b0;
    endcase
    if (take) begin
      pc_d = word.target;
    end else if (word.stay) begin
      pc_d = pc_q;
    end else begin
      pc_d = nps_pkg::step_e'(4'(pc_q + 4'd1));
    end
  end

  // Control word out
  always_comb begin
    ctrl_o = word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= nps_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ rtl/nps_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_datapath
// Job table, scan compare, time registers and the result register.
// ----------------------------------------------------------------------------
module nps_datapath #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nps_pkg::ctrl_t   ctrl_i,
  output nps_pkg::status_t status_o,
  input  logic             in_valid_i,
  input  logic [7:0]       process_id_i,
  input  logic [15:0]      arrival_time_i,
  input  logic [15:0]      run_time_i,
  input  logic [7:0]       priority_level_i,
  input  logic             last_job_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       sched_id_o,
  output logic [20:0]      start_time_o,
  output logic [20:0]      end_time_o,
  output logic [20:0]      turnaround_o,
  output logic [20:0]      waiting_o,
  output logic             last_result_o
);

  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned TW = 16 + $clog2(MAX_JOBS + 1);
  localparam int unsigned OW = (TW > nps_pkg::TIME_OUT_W) ? TW : nps_pkg::TIME_OUT_W;

  nps_pkg::job_t mem [MAX_JOBS];
  nps_pkg::job_t rd_q;
  nps_pkg::job_t best_q, best_d;
  nps_pkg::job_t in_job;

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       n_q, n_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic [OW-1:0]       cur_q, cur_d;
  logic [OW-1:0]       prev_q, prev_d;
  logic [OW-1:0]       start_q, start_d;
  logic [OW-1:0]       end_q, end_d;
  logic [OW-1:0]       end_sum;
  logic [15:0]         next_arr_q, next_arr_d;
  logic                pend_q, pend_d;
  logic                found_q, found_d;
  logic [AW-1:0]       best_k_q, best_k_d;
  logic [AW-1:0]       k;
  logic                wr_en;
  logic                out_free;
  logic                e_live;
  logic                better;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_id_q, out_id_d;
  logic [20:0] out_start_q, out_start_d;
  logic [20:0] out_end_q, out_end_d;
  logic [20:0] out_turn_q, out_turn_d;
  logic [20:0] out_wait_q, out_wait_d;
  logic        out_last_q, out_last_d;

  assign in_job   = '{id: process_id_i, arr: arrival_time_i, run: run_time_i,
                      prio: priority_level_i};
  assign wr_en    = in_valid_i && ctrl_i.load && (count_q < CW'(MAX_JOBS));
  assign out_free = !out_valid_q || !out_stall_i;
  assign k        = idx_q[AW-1:0];
  assign e_live   = !done_q[k];
  assign better   = !found_q || (rd_q.prio > best_q.prio) ||
                    ((rd_q.prio == best_q.prio) && (rd_q.arr < best_q.arr));
  assign end_sum  = start_q + OW'(best_q.run);

  always_comb begin
    status_o.acc_last     = in_valid_i && ctrl_i.load && last_job_i;
    status_o.more_entries = (CW'(idx_q + CW'(1)) != count_q);
    status_o.found        = found_q;
    status_o.no_pend      = !pend_q;
    status_o.out_free     = out_free;
    status_o.more_jobs    = (n_q != count_q);
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    n_d         = n_q;
    done_d      = done_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    start_d     = start_q;
    end_d       = end_q;
    next_arr_d  = next_arr_q;
    pend_d      = pend_q;
    found_d     = found_q;
    best_k_d    = best_k_q;
    best_d      = best_q;
    out_valid_d = out_valid_q;
    out_id_d    = out_id_q;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_turn_d  = out_turn_q;
    out_wait_d  = out_wait_q;
    out_last_d  = out_last_q;

    if (wr_en) begin
      count_d = CW'(count_q + CW'(1));
    end
    if (ctrl_i.init) begin
      cur_d  = '0;
      prev_d = '0;
      done_d = '0;
      n_d    = '0;
    end
    if (ctrl_i.scan_clr) begin
      idx_d   = '0;
      found_d = 1'b0;
      pend_d  = 1'b0;
    end
    if (ctrl_i.scan) begin
      idx_d = CW'(idx_q + CW'(1));
      if (e_live) begin
        pend_d = 1'b1;
        if (!pend_q || (rd_q.arr < next_arr_q)) begin
          next_arr_d = rd_q.arr;
        end
        if ((OW'(rd_q.arr) <= cur_q) && better) begin
          found_d  = 1'b1;
          best_k_d = k;
          best_d   = rd_q;
        end
      end
    end
    // Nothing has arrived: jump to the earliest pending arrival.
    if (ctrl_i.set_time) begin
      cur_d = OW'(next_arr_q);
    end
    if (ctrl_i.pick_start) begin
      start_d = (prev_q > OW'(best_q.arr)) ? prev_q : OW'(best_q.arr);
    end
    if (ctrl_i.pick_end) begin
      end_d            = end_sum;
      cur_d            = end_sum;
      prev_d           = end_sum;
      done_d[best_k_q] = 1'b1;
      n_d              = CW'(n_q + CW'(1));
    end
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.emit && out_free) begin
      out_valid_d = 1'b1;
      out_id_d    = best_q.id;
      out_start_d = start_q[20:0];
      out_end_d   = end_q[20:0];
      out_turn_d  = 21'(end_q - OW'(best_q.arr));
      out_wait_d  = 21'(start_q - OW'(best_q.arr));
      out_last_d  = (n_q == count_q);
    end
    if (ctrl_i.finish) begin
      count_d = '0;
      done_d  = '0;
      cur_d   = '0;
    end
  end

  // Job table: write on load, read one entry ahead of the scan index.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= in_job;
    end
    rd_q <= mem[idx_d[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      done_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      done_q      <= done_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    end_q       <= end_d;
    next_arr_q  <= next_arr_d;
    best_k_q    <= best_k_d;
    best_q      <= best_d;
    out_id_q    <= out_id_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_turn_q  <= out_turn_d;
    out_wait_q  <= out_wait_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign sched_id_o    = out_id_q;
  assign start_time_o  = out_start_q;
  assign end_time_o    = out_end_q;
  assign turnaround_o  = out_turn_q;
  assign waiting_o     = out_wait_q;
  assign last_result_o = out_last_q;

endmodule

@@ rtl/nonpreemptive_priority_scheduler_core.sv @@
`timescale 1ns / 1ps
// A job request loads while the core is in its load step; a set of jobs is scheduled
// after its last request, with a fresh scan after each idle-time jump.
// Each result scans one job-table entry per cycle through the single
// table read port, then does the pick, end-time add and result load.
// Reset (async, active low) empties the set and drops any pending result.
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// Microcoded non-preemptive priority scheduler over a loaded job set.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_core #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  process_id_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] run_time_i,
  input  logic [7:0]  priority_level_i,
  input  logic        last_job_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  sched_id_o,
  output logic [20:0] start_time_o,
  output logic [20:0] end_time_o,
  output logic [20:0] turnaround_o,
  output logic [20:0] waiting_o,
  output logic        last_result_o
);

  nps_pkg::ctrl_t   ctrl;
  nps_pkg::status_t status;

  nps_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  nps_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .in_valid_i       (in_valid_i),
    .process_id_i     (process_id_i),
    .arrival_time_i   (arrival_time_i),
    .run_time_i       (run_time_i),
    .priority_level_i (priority_level_i),
    .last_job_i       (last_job_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sched_id_o       (sched_id_o),
    .start_time_o     (start_time_o),
    .end_time_o       (end_time_o),
    .turnaround_o     (turnaround_o),
    .waiting_o        (waiting_o),
    .last_result_o    (last_result_o)
  );

  // Take requests only in the load step.
  assign in_stall_o = !ctrl.load;

  // Both differences equal the run time of the job.
  a_run_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (21'(end_time_o - start_time_o) == 21'(turnaround_o - waiting_o)))
    else $error("result times disagree on run time");

  a_busy_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_job_i) |=> in_stall_o)
    else $error("request taken right after last job");

  a_result_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_stall_o)
    else $error("result loaded outside scheduling");

endmodule
